[rtl/bole_pkg.sv]
// Shared types and codes for the bounded ordered list engine.
// Used by bole_cell and bounded_ordered_list_engine; no dependencies.
package bole_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_FRONT  = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_POS    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST  = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_VALUE  = 3'd5;
    localparam logic [OP_W-1:0] OP_DEL_POS    = 3'd6;
    localparam logic [OP_W-1:0] OP_DISPLAY    = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_DELVAL,
        CELL_ROTATE
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

endpackage

[rtl/bole_cell.sv]
// One storage cell of the list chain: holds one element and shifts,
// inserts, rotates or matches with its neighbors. Depends on bole_pkg.
module bole_cell #(
    parameter int DEPTH = 16,
    parameter int IDX   = 0
) (
    input  logic                                  aclk,
    input  bole_pkg::cell_cmd_t                   cmd,
    input  logic [$clog2(DEPTH)-1:0]              pos,
    input  logic [$clog2(DEPTH+1)-1:0]            length,
    input  logic signed [bole_pkg::DATA_W-1:0]    prev_data,
    input  logic signed [bole_pkg::DATA_W-1:0]    next_data,
    input  logic signed [bole_pkg::DATA_W-1:0]    head_data,
    input  logic                                  found_in,
    output logic                                  found_out,
    output logic signed [bole_pkg::DATA_W-1:0]    data_out
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] IDX_I = IW'(IDX);
    localparam logic [LW-1:0] IDX_L = LW'(IDX);

    logic signed [bole_pkg::DATA_W-1:0] data_reg;
    logic signed [bole_pkg::DATA_W-1:0] data_next;
    logic                               match;

    assign match     = (data_reg == cmd.value) && (IDX_L < length);
    assign found_out = found_in || match;
    assign data_out  = data_reg;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            bole_pkg::CELL_INSERT: begin
                if (IDX_I > pos) begin
                    data_next = prev_data;
                end else if (IDX_I == pos) begin
                    data_next = cmd.value;
                end
            end
            bole_pkg::CELL_DELETE: begin
                if (IDX_I >= pos) begin
                    data_next = next_data;
                end
            end
            bole_pkg::CELL_DELVAL: begin
                if (found_out) begin
                    data_next = next_data;
                end
            end
            bole_pkg::CELL_ROTATE: begin
                if (IDX_I == pos) begin
                    data_next = head_data;
                end else begin
                    data_next = next_data;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

[rtl/bounded_ordered_list_engine.sv]
// Bounded ordered list engine: a chain of DEPTH cells holding the list.
// An accepted update's result is registered for the next cycle. Display
// enters S_DISP, then registers the head element and rotates the chain
// once per element, one element a cycle while results are taken. Updates
// flow one item per cycle while results are taken; none during a display.
// Reset (aresetn low, synchronous) empties the list and drops any result.
module bounded_ordered_list_engine #(
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [bole_pkg::OP_W-1:0]             s_operation,
    input  logic signed [bole_pkg::DATA_W-1:0]    s_value,
    input  logic [bole_pkg::POS_W-1:0]            s_position,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [bole_pkg::DATA_W-1:0]    m_data,
    output logic [bole_pkg::INDEX_W-1:0]          m_index,
    output logic                                  m_last,
    output logic [bole_pkg::COUNT_W-1:0]          m_count,
    output logic [bole_pkg::STATUS_W-1:0]         m_status
);

    localparam int IW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int CW = (LW + 1 > bole_pkg::POS_W + 1) ? LW + 1 : bole_pkg::POS_W + 1;

    typedef enum logic {
        S_IDLE,
        S_DISP
    } state_t;

    state_t                             state_reg;
    logic [LW-1:0]                      len_reg;
    logic [LW-1:0]                      len_next;
    logic [IW-1:0]                      k_reg;
    logic                               m_valid_reg;
    logic                               m_valid_next;
    logic signed [bole_pkg::DATA_W-1:0] m_data_reg;
    logic [bole_pkg::INDEX_W-1:0]       m_index_reg;
    logic                               m_last_reg;
    logic [bole_pkg::COUNT_W-1:0]       m_count_reg;
    logic [bole_pkg::STATUS_W-1:0]      m_status_reg;

    bole_pkg::cell_cmd_t                cmd;
    logic [IW-1:0]                      cell_pos;
    logic [bole_pkg::STATUS_W-1:0]      status_next;
    logic                               out_free;
    logic                               out_load;
    logic                               accept;
    logic                               full;
    logic                               empty;
    logic                               found;
    logic                               disp_last;
    logic [IW-1:0]                      last_idx;
    logic [CW-1:0]                      pos_ext;
    logic [CW-1:0]                      len_ext;

    logic signed [bole_pkg::DATA_W-1:0] cell_data [DEPTH];
    logic                               cell_found [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic signed [bole_pkg::DATA_W-1:0] prev_d;
            logic signed [bole_pkg::DATA_W-1:0] next_d;
            logic                               fin;
            if (g == 0) begin : g_first
                assign prev_d = cmd.value;
                assign fin    = 1'b0;
            end else begin : g_mid
                assign prev_d = cell_data[g-1];
                assign fin    = cell_found[g-1];
            end
            if (g == DEPTH - 1) begin : g_end
                assign next_d = cell_data[g];
            end else begin : g_inner
                assign next_d = cell_data[g+1];
            end
            bole_cell #(
                .DEPTH (DEPTH),
                .IDX   (g)
            ) u_cell (
                .aclk      (aclk),
                .cmd       (cmd),
                .pos       (cell_pos),
                .length    (len_reg),
                .prev_data (prev_d),
                .next_data (next_d),
                .head_data (cell_data[0]),
                .found_in  (fin),
                .found_out (cell_found[g]),
                .data_out  (cell_data[g])
            );
        end
    endgenerate

    assign found     = cell_found[DEPTH-1];
    assign full      = (len_reg == LW'(DEPTH));
    assign empty     = (len_reg == '0);
    assign last_idx  = IW'(len_reg - LW'(1));
    assign disp_last = (k_reg == last_idx);
    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE) && out_free;
    assign accept    = s_valid && s_ready;
    assign pos_ext   = CW'(s_position);
    assign len_ext   = CW'(len_reg);

    assign out_load     = (state_reg == S_DISP) ? out_free
                        : (accept && !(s_operation == bole_pkg::OP_DISPLAY && !empty));
    assign m_valid_next = out_load || (m_valid_reg && !m_ready);

    always_comb begin
        cmd.op      = bole_pkg::CELL_HOLD;
        cmd.value   = s_value;
        cell_pos    = '0;
        len_next    = len_reg;
        status_next = bole_pkg::ST_OK;
        if (accept) begin
            case (s_operation)
                bole_pkg::OP_APPEND: begin
                    if (full) begin
                        status_next = bole_pkg::ST_FULL;
                    end else begin
                        cmd.op   = bole_pkg::CELL_INSERT;
                        cell_pos = IW'(len_reg);
                        len_next = len_reg + LW'(1);
                    end
                end
                bole_pkg::OP_INS_FRONT: begin
                    if (full) begin
                        status_next = bole_pkg::ST_FULL;
                    end else begin
                        cmd.op   = bole_pkg::CELL_INSERT;
                        len_next = len_reg + LW'(1);
                    end
                end
                bole_pkg::OP_INS_POS: begin
                    if (full) begin
                        status_next = bole_pkg::ST_FULL;
                    end else if (pos_ext == '0 || pos_ext > len_ext + CW'(1)) begin
                        status_next = bole_pkg::ST_BADPOS;
                    end else begin
                        cmd.op   = bole_pkg::CELL_INSERT;
                        cell_pos = IW'(pos_ext - CW'(1));
                        len_next = len_reg + LW'(1);
                    end
                end
                bole_pkg::OP_DEL_FIRST: begin
                    if (empty) begin
                        status_next = bole_pkg::ST_EMPTY;
                    end else begin
                        cmd.op   = bole_pkg::CELL_DELETE;
                        len_next = len_reg - LW'(1);
                    end
                end
                bole_pkg::OP_DEL_LAST: begin
                    if (empty) begin
                        status_next = bole_pkg::ST_EMPTY;
                    end else begin
                        len_next = len_reg - LW'(1);
                    end
                end
                bole_pkg::OP_DEL_VALUE: begin
                    if (empty) begin
                        status_next = bole_pkg::ST_EMPTY;
                    end else if (!found) begin
                        status_next = bole_pkg::ST_NOTFOUND;
                    end else begin
                        cmd.op   = bole_pkg::CELL_DELVAL;
                        len_next = len_reg - LW'(1);
                    end
                end
                bole_pkg::OP_DEL_POS: begin
                    if (empty) begin
                        status_next = bole_pkg::ST_EMPTY;
                    end else if (pos_ext == '0 || pos_ext > len_ext) begin
                        status_next = bole_pkg::ST_BADPOS;
                    end else begin
                        cmd.op   = bole_pkg::CELL_DELETE;
                        cell_pos = IW'(pos_ext - CW'(1));
                        len_next = len_reg - LW'(1);
                    end
                end
                default: begin
                    if (empty) begin
                        status_next = bole_pkg::ST_EMPTY;
                    end
                end
            endcase
        end else if (state_reg == S_DISP && out_free) begin
            // rotate: head moves to the tail, next element comes to the head
            cmd.op   = bole_pkg::CELL_ROTATE;
            cell_pos = last_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg     <= len_next;
            m_valid_reg <= m_valid_next;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        if (s_operation == bole_pkg::OP_DISPLAY && !empty) begin
                            state_reg <= S_DISP;
                            k_reg     <= '0;
                        end else begin
                            m_data_reg   <= '0;
                            m_index_reg  <= '0;
                            m_last_reg   <= 1'b1;
                            m_count_reg  <= bole_pkg::COUNT_W'(len_next);
                            m_status_reg <= status_next;
                        end
                    end
                end
                S_DISP: begin
                    if (out_free) begin
                        m_data_reg   <= cell_data[0];
                        m_index_reg  <= bole_pkg::INDEX_W'(k_reg);
                        m_last_reg   <= disp_last;
                        m_count_reg  <= bole_pkg::COUNT_W'(len_reg);
                        m_status_reg <= bole_pkg::ST_OK;
                        k_reg        <= k_reg + IW'(1);
                        if (disp_last) begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign m_index  = m_index_reg;
    assign m_last   = m_last_reg;
    assign m_count  = m_count_reg;
    assign m_status = m_status_reg;

endmodule
